>>> design/spd_pkg.sv
package spd_pkg;

    localparam int BUF_BYTES = 16;
    localparam int IDX_W     = $clog2(BUF_BYTES);
    localparam int CNT_W     = $clog2(BUF_BYTES + 1);

    localparam logic [7:0] SUM_MASK = 8'h7F;

    typedef enum logic [1:0]
    {
        PH_START = 2'd0,
        PH_LEN   = 2'd1,
        PH_DATA  = 2'd2,
        PH_SUM   = 2'd3
    } phase_t;

    typedef enum logic [1:0]
    {
        RES_GOOD     = 2'd0,
        RES_BAD_SUM  = 2'd1,
        RES_TOO_LONG = 2'd2
    } res_code_t;

    typedef struct packed
    {
        logic [1:0]         result_code;
        logic [7:0]         payload_length;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] heading;
        logic [7:0]         manual_flag;
        logic [7:0]         path_flag;
    } result_t;

endpackage

>>> design/spd_parser.sv
module spd_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          sync_byte,
    input  logic                take,
    input  logic [7:0]          rx_byte,
    output logic                res_valid,
    output spd_pkg::result_t    res
);
    import spd_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [7:0]       sum_reg, sum_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] exp_len_reg, exp_len_next;
    logic [7:0]       store_reg [BUF_BYTES];
    logic             store_we;
    logic [CNT_W-1:0] count_inc;
    logic [7:0]       sum_add;
    logic             sum_ok;

    assign count_inc = count_reg + 1'b1;
    assign sum_add   = sum_reg + rx_byte;
    assign sum_ok    = (rx_byte == (sum_reg & SUM_MASK));

    always_comb
    begin
        phase_next   = phase_reg;
        sum_next     = sum_reg;
        count_next   = count_reg;
        exp_len_next = exp_len_reg;
        store_we     = 1'b0;
        res_valid    = 1'b0;
        res          = '0;
        if (take)
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    if (rx_byte == sync_byte)
                    begin
                        sum_next   = rx_byte;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    sum_next = sum_add;
                    if (rx_byte > 8'(BUF_BYTES))
                    begin
                        phase_next         = PH_START;
                        res_valid          = 1'b1;
                        res.result_code    = RES_TOO_LONG;
                        res.payload_length = rx_byte;
                    end
                    else
                    begin
                        exp_len_next = rx_byte[CNT_W-1:0];
                        count_next   = '0;
                        phase_next   = (rx_byte == 8'd0) ? PH_SUM : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    store_we   = (count_reg < CNT_W'(BUF_BYTES));
                    sum_next   = sum_add;
                    count_next = count_inc;
                    if (count_inc >= exp_len_reg)
                    begin
                        phase_next = PH_SUM;
                    end
                end
                PH_SUM:
                begin
                    phase_next         = PH_START;
                    res_valid          = 1'b1;
                    res.payload_length = 8'(exp_len_reg);
                    if (sum_ok)
                    begin
                        res.result_code = RES_GOOD;
                        res.pos_x       = {store_reg[1], store_reg[0]};
                        res.pos_y       = {store_reg[3], store_reg[2]};
                        res.heading     = {store_reg[5], store_reg[4]};
                        res.manual_flag = store_reg[6];
                        res.path_flag   = store_reg[7];
                    end
                    else
                    begin
                        res.result_code = RES_BAD_SUM;
                    end
                end
                default:
                begin
                    phase_next = PH_START;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            sum_reg     <= '0;
            count_reg   <= '0;
            exp_len_reg <= '0;
            for (int i = 0; i < BUF_BYTES; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else
        begin
            phase_reg   <= phase_next;
            sum_reg     <= sum_next;
            count_reg   <= count_next;
            exp_len_reg <= exp_len_next;
            if (store_we)
            begin
                store_reg[count_reg[IDX_W-1:0]] <= rx_byte;
            end
        end
    end

endmodule

>>> design/spd_out_reg.sv
module spd_out_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  spd_pkg::result_t    res_in,
    input  logic                out_stall,
    output logic                out_valid,
    output spd_pkg::result_t    res_out
);
    import spd_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

>>> design/status_packet_deframer.sv
// Status packet deframer.
// Input channel: in_valid / in_stall carry one received byte (rx_byte) per item.
// Packets are: start byte, length byte, payload bytes, checksum byte.
// Output channel: out_valid / out_stall carry one result item per finished
// packet (checksum byte) or per rejected oversize length byte.
// Config channel: cfg_valid / cfg_ready write the start byte; cfg_ready is
// always high. Write only while no packet is in progress.
// A result is registered and appears in the cycle after the byte that ends the packet.
// Throughput: one byte per cycle while in_stall is low; the parser state and the
// status store update once per taken byte, with one result register behind them.
// in_stall rises only while a result sits in the output register and the
// receiver stalls it; the held result stays stable until taken.
// Reset clears the parser, the 16-byte status store and the start byte
// (to zero); no result is pending after reset.
module status_packet_deframer
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_sync_byte,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         result_code,
    output logic [7:0]         payload_length,
    output logic signed [15:0] pos_x,
    output logic signed [15:0] pos_y,
    output logic signed [15:0] heading,
    output logic [7:0]         manual_flag,
    output logic [7:0]         path_flag
);
    import spd_pkg::*;

    logic [7:0] start_reg;
    logic       take;
    logic       res_valid;
    result_t    res;
    result_t    res_q;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid & out_stall;
    assign take      = in_valid & ~in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            start_reg <= cfg_sync_byte;
        end
    end

    spd_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .sync_byte  (start_reg),
        .take       (take),
        .rx_byte    (rx_byte),
        .res_valid  (res_valid),
        .res        (res)
    );

    spd_out_reg u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res_in    (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .res_out   (res_q)
    );

    assign result_code    = res_q.result_code;
    assign payload_length = res_q.payload_length;
    assign pos_x          = res_q.pos_x;
    assign pos_y          = res_q.pos_y;
    assign heading        = res_q.heading;
    assign manual_flag    = res_q.manual_flag;
    assign path_flag      = res_q.path_flag;

endmodule

>>> test/tb_status_packet_deframer.sv
`timescale 1ns / 1ps

module tb_status_packet_deframer;

    import spd_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 60;
    localparam int SETTLE       = 4;
    localparam int PHASE_ITEMS  = 190;

    class status_frame_board;
        logic [7:0] start_sel;
        phase_t     phase;
        logic [7:0] sum;
        int         count;
        int         want_len;
        logic [7:0] store [BUF_BYTES];
        result_t    due_results [$];
        int         errors;

        function new();
            start_sel = 8'h00;
            phase     = PH_START;
            sum       = 8'h00;
            count     = 0;
            want_len  = 0;
            errors    = 0;
            foreach (store[i])
            begin
                store[i] = 8'h00;
            end
        endfunction

        function void finish_packet(res_code_t code, logic [7:0] len);
            result_t r;
            r = '0;
            r.result_code    = code;
            r.payload_length = len;
            if (code == RES_GOOD)
            begin
                r.pos_x       = {store[1], store[0]};
                r.pos_y       = {store[3], store[2]};
                r.heading     = {store[5], store[4]};
                r.manual_flag = store[6];
                r.path_flag   = store[7];
            end
            due_results.push_back(r);
        endfunction

        function void take_byte(logic [7:0] b);
            case (phase)
                PH_START:
                begin
                    if (b == start_sel)
                    begin
                        sum   = b;
                        phase = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    sum = sum + b;
                    if (b > BUF_BYTES)
                    begin
                        phase = PH_START;
                        finish_packet(RES_TOO_LONG, b);
                    end
                    else
                    begin
                        want_len = int'(b);
                        count    = 0;
                        phase    = (b == 8'd0) ? PH_SUM : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    if (count < BUF_BYTES)
                        store[count] = b;
                    sum   = sum + b;
                    count = count + 1;
                    if (count >= want_len)
                        phase = PH_SUM;
                end
                default:
                begin
                    phase = PH_START;
                    if (b == (sum & SUM_MASK))
                        finish_packet(RES_GOOD, want_len[7:0]);
                    else
                        finish_packet(RES_BAD_SUM, want_len[7:0]);
                end
            endcase
        endfunction

        task report(string msg);
            errors = errors + 1;
            $display("ERROR at %0t: %s", $time, msg);
        endtask

        task check(result_t got);
            result_t want;
            if (due_results.size() == 0)
            begin
                report("result with no packet pending");
                return;
            end
            want = due_results.pop_front();
            if (got.result_code !== want.result_code)
                report($sformatf("result_code %0d, want %0d",
                                 got.result_code, want.result_code));
            if (got.payload_length !== want.payload_length)
                report($sformatf("payload_length %0d, want %0d",
                                 got.payload_length, want.payload_length));
            if (got.pos_x !== want.pos_x)
                report($sformatf("pos_x %0d, want %0d", got.pos_x, want.pos_x));
            if (got.pos_y !== want.pos_y)
                report($sformatf("pos_y %0d, want %0d", got.pos_y, want.pos_y));
            if (got.heading !== want.heading)
                report($sformatf("heading %0d, want %0d", got.heading, want.heading));
            if (got.manual_flag !== want.manual_flag)
                report($sformatf("manual_flag %0d, want %0d",
                                 got.manual_flag, want.manual_flag));
            if (got.path_flag !== want.path_flag)
                report($sformatf("path_flag %0d, want %0d",
                                 got.path_flag, want.path_flag));
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [7:0]         cfg_sync_byte;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         rx_byte;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         result_code;
    logic [7:0]         payload_length;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] heading;
    logic [7:0]         manual_flag;
    logic [7:0]         path_flag;

    status_frame_board sb = new();

    logic [7:0] cur_start = 8'h00;
    int         sent      = 0;
    bit         src_idle  = 1'b1;
    bit         sink_idle = 1'b1;
    bit         long_hold = 1'b0;

    status_packet_deframer dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_sync_byte  (cfg_sync_byte),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_code    (result_code),
        .payload_length (payload_length),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .heading        (heading),
        .manual_flag    (manual_flag),
        .path_flag      (path_flag)
    );

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    always @(posedge clk)
    begin : monitor
        result_t got;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.take_byte(rx_byte);
            if (cfg_valid && cfg_ready)
                sb.start_sel = cfg_sync_byte;
            if (out_valid && !out_stall)
            begin
                got = {result_code, payload_length, pos_x, pos_y, heading,
                       manual_flag, path_flag};
                sb.check(got);
            end
        end
    end

    initial
    begin : sink
        int n;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                long_hold = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (sink_idle && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 5);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int n;
        if (src_idle && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // a payload shorter than len leaves the packet cut short
    task automatic send_packet(input logic [7:0] len, input logic [7:0] pay [$],
                               input bit good);
        logic [7:0] s;
        logic [7:0] ck;
        sent = sent + 2 + pay.size()
             + ((len <= BUF_BYTES && pay.size() >= len) ? 1 : 0);
        s = cur_start;
        s = s + len;
        send_byte(cur_start);
        send_byte(len);
        if (len > BUF_BYTES)
            return;
        foreach (pay[i])
        begin
            s = s + pay[i];
            send_byte(pay[i]);
        end
        if (pay.size() < len)
            return;
        ck = s & SUM_MASK;
        if (!good)
        begin
            ck = 8'($urandom);
            if (ck == (s & SUM_MASK))
                ck[7] = 1'b1;
        end
        send_byte(ck);
    endtask

    task automatic random_chunk();
        int         kind;
        int         len;
        int         n;
        logic [7:0] b;
        logic [7:0] pay [$];
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            n = $urandom_range(1, 4);
            repeat (n)
            begin
                b = 8'($urandom);
                if (b == cur_start)
                    b = b ^ 8'h01;
                send_byte(b);
            end
        end
        else if (kind < 16)
        begin
            send_packet(8'($urandom_range(BUF_BYTES + 1, 255)), pay, 1'b1);
        end
        else
        begin
            len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 8)
                                             : $urandom_range(9, BUF_BYTES);
            repeat (len)
            begin
                b = 8'($urandom);
                pay.push_back(b);
            end
            if (kind < 24 && len > 0)
            begin
                n = $urandom_range(1, len);
                repeat (n) void'(pay.pop_back());
            end
            send_packet(8'(len), pay, kind < 70);
        end
    endtask

    // idle the input, let pending results drain, and close any open packet
    task automatic settle();
        forever
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (sb.due_results.size() != 0)
                @(posedge clk);
            repeat (SETTLE) @(posedge clk);
            if (sb.phase == PH_START)
                return;
            send_byte(8'hFF);
        end
    endtask

    task automatic write_start(input logic [7:0] v);
        cfg_valid     <= 1'b1;
        cfg_sync_byte <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_start = v;
    endtask

    initial
    begin : stimulus
        logic [7:0] pay [$];
        logic [7:0] next_start;
        int         target;
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_sync_byte <= 8'h00;
        in_valid      <= 1'b0;
        rx_byte       <= 8'h00;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: ignored byte, field extremes, zero length, oversize,
        // failed checksum, checksum with bit 7 set
        send_byte(8'h5A);
        pay = {8'hFF, 8'h7F, 8'h80, 8'h00, 8'h01, 8'hFE, 8'hFF, 8'h00};
        send_packet(8'd8, pay, 1'b1);
        pay = {8'h12, 8'h34};
        send_packet(8'd2, pay, 1'b0);
        pay.delete();
        send_packet(8'd0, pay, 1'b1);
        send_packet(8'd17, pay, 1'b1);
        send_packet(8'd255, pay, 1'b1);
        send_byte(cur_start);
        send_byte(8'd0);
        send_byte(8'h80);

        for (int ph = 0; ph < 6; ph++)
        begin
            settle();
            case (ph)
                0:       next_start = 8'hFF;
                2:       next_start = 8'h00;
                4:       next_start = 8'h7F;
                default: next_start = 8'($urandom);
            endcase
            write_start(next_start);
            if (ph == 2)
                long_hold = 1'b1;
            if (ph == 5)
            begin
                src_idle  = 1'b0;
                sink_idle = 1'b0;
            end
            target = sent + PHASE_ITEMS;
            while (sent < target)
                random_chunk();
        end
        settle();

        if (sb.due_results.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.due_results.size()));
        if (sb.errors == 0)
            $display("status_packet_deframer: match");
        else
            $display("status_packet_deframer: mismatch");
        $finish;
    end

    initial
    begin : watchdog
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("status_packet_deframer: mismatch");
        $finish;
    end

endmodule
